>>> hw/rtl/mtfe_pkg.sv
// Shared types and constants for the move-to-front encoder.
// Used by mtfe_cell, mtfe_out and move_to_front_encoder; no dependencies.
`timescale 1ns / 1ps

package mtfe_pkg;

    localparam int SYM_W  = 8;
    localparam int COST_W = 40;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Rank reported for a symbol that lies outside the alphabet
    localparam logic [SYM_W-1:0] RANK_OOB = {SYM_W{1'b1}};

    // Item as it travels down the cell chain
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             found;
        logic [SYM_W-1:0] rank;
        logic [SYM_W-1:0] carry;
    } mtfe_token_t;

endpackage

>>> hw/rtl/move_to_front_encoder.sv
// Top level of the move-to-front encoder: a chain of ALPHABET cells and an output stage.
// Depends on mtfe_pkg, mtfe_cell and mtfe_out.
`timescale 1ns / 1ps

// Move-to-front encoder. Each accepted symbol yields one result: its position in the
// current symbol order (0 is the front) and the saturating running total of rank plus
// one for the block so far. The order is held one entry per cell in a chain of ALPHABET
// cells; a symbol walks down the chain one cell per cycle when not stalled, shifting entries
// back until it meets its match, so a new symbol is taken every cycle while not stalled,
// and each result passes through every cell and then the output register.
// After a symbol marked last in block, every cell it passes returns to identity order and
// the total restarts at zero for the next symbol. Symbols at or above ALPHABET leave the
// order untouched and report rank 255. Reset restores identity order at once.

module move_to_front_encoder #(
    parameter int ALPHABET = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mtfe_pkg::SYM_W-1:0]  symbol,
    input  logic                        last_in_block,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mtfe_pkg::SYM_W-1:0]  rank,
    output logic [mtfe_pkg::COST_W-1:0] total_cost
);

    import mtfe_pkg::*;

    logic        advance;
    logic        oob;
    mtfe_token_t head_tok;
    logic        chain_valid [ALPHABET];
    mtfe_token_t chain_tok   [ALPHABET];

    // Build the token entering the front cell
    assign oob = ({1'b0, symbol} >= (SYM_W + 1)'(ALPHABET));

    always_comb
    begin
        head_tok.symbol = symbol;
        head_tok.last   = last_in_block;
        head_tok.found  = oob;
        head_tok.rank   = RANK_OOB;
        head_tok.carry  = symbol;
    end

    assign in_stall = !advance;

    // Chain of order cells
    for (genvar i = 0; i < ALPHABET; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            mtfe_cell #(
                .INDEX (SYM_W'(i))
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .up_valid (in_valid),
                .up_tok   (head_tok),
                .dn_valid (chain_valid[i]),
                .dn_tok   (chain_tok[i])
            );
        end
        else
        begin : g_body
            mtfe_cell #(
                .INDEX (SYM_W'(i))
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .up_valid (chain_valid[i-1]),
                .up_tok   (chain_tok[i-1]),
                .dn_valid (chain_valid[i]),
                .dn_tok   (chain_tok[i])
            );
        end
    end

    // Cost total and result register
    mtfe_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (chain_valid[ALPHABET-1]),
        .up_tok     (chain_tok[ALPHABET-1]),
        .out_stall  (out_stall),
        .advance    (advance),
        .out_valid  (out_valid),
        .rank       (rank),
        .total_cost (total_cost)
    );

endmodule

>>> hw/rtl/mtfe_cell.sv
// One cell of the move-to-front chain: holds one entry of the symbol order.
// Depends on mtfe_pkg for the token type.
`timescale 1ns / 1ps

module mtfe_cell #(
    parameter logic [mtfe_pkg::SYM_W-1:0] INDEX = '0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                up_valid,
    input  mtfe_pkg::mtfe_token_t up_tok,
    output logic                dn_valid,
    output mtfe_pkg::mtfe_token_t dn_tok
);

    import mtfe_pkg::*;

    logic [SYM_W-1:0] value_reg;
    logic [SYM_W-1:0] value_next;
    logic             valid_reg;
    mtfe_token_t      tok_reg;
    mtfe_token_t      tok_next;

    // Shift the displaced symbol in until the match is found, then leave the entry alone
    always_comb
    begin
        tok_next   = up_tok;
        value_next = value_reg;
        if (!up_tok.found)
        begin
            value_next = up_tok.carry;
            if (value_reg == up_tok.symbol)
            begin
                tok_next.found = 1'b1;
                tok_next.rank  = INDEX;
            end
            else
            begin
                tok_next.carry = value_reg;
            end
        end
        // Restore identity order behind the last symbol of a block
        if (up_tok.last)
        begin
            value_next = INDEX;
        end
    end

    // Hold the order entry and the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= INDEX;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
            if (up_valid)
            begin
                value_reg <= value_next;
            end
        end
    end

    // Advance the token payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_tok   = tok_reg;

endmodule

>>> hw/rtl/mtfe_out.sv
// Output stage of the move-to-front encoder: saturating cost total and result register.
// Depends on mtfe_pkg for the token type and the cost constants.
`timescale 1ns / 1ps

module mtfe_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    input  mtfe_pkg::mtfe_token_t        up_tok,
    input  logic                         out_stall,
    output logic                         advance,
    output logic                         out_valid,
    output logic [mtfe_pkg::SYM_W-1:0]   rank,
    output logic [mtfe_pkg::COST_W-1:0]  total_cost
);

    import mtfe_pkg::*;

    logic              valid_reg;
    logic [SYM_W-1:0]  rank_reg;
    logic [COST_W-1:0] total_reg;
    logic [COST_W-1:0] cost_sum_reg;
    logic [COST_W-1:0] cost_sum_next;
    logic [COST_W-1:0] sum_sat;
    logic [SYM_W:0]    add;
    logic              load;

    // Move the chain whenever the result register is free or being taken
    assign advance = !valid_reg || !out_stall;
    assign load    = advance && up_valid;

    // Add rank plus one, clamp at the top
    always_comb
    begin
        add = {1'b0, up_tok.rank} + {{SYM_W{1'b0}}, 1'b1};
        if (cost_sum_reg > (COST_MAX - COST_W'(add)))
        begin
            sum_sat = COST_MAX;
        end
        else
        begin
            sum_sat = cost_sum_reg + COST_W'(add);
        end
        cost_sum_next = up_tok.last ? '0 : sum_sat;
    end

    // Hold control state: output valid and the running total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            cost_sum_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
            if (up_valid)
            begin
                cost_sum_reg <= cost_sum_next;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rank_reg  <= up_tok.rank;
            total_reg <= sum_sat;
        end
    end

    assign out_valid  = valid_reg;
    assign rank       = rank_reg;
    assign total_cost = total_reg;

`ifndef SYNTHESIS
    // A block end clears the running total
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (load && up_tok.last) |=> (cost_sum_reg == '0))
        else $error("cost total not cleared after block end");

    // Reported total always covers the reported symbol's own cost
    a_total_covers_rank: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (total_reg >= (COST_W'(rank_reg) + COST_W'(1))))
        else $error("total cost below rank plus one");

    // Within a block the total never falls
    a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !up_tok.last) |=> (cost_sum_reg >= $past(cost_sum_reg)))
        else $error("cost total decreased within a block");

    // Stalled output leaves the running total alone
    a_stall_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cost_sum_reg))
        else $error("cost total changed while stalled");
`endif

endmodule
